### rtl/psrm_pkg.sv
`default_nettype none
package psrm_pkg;

	localparam logic [15:0] IPV4_TYPE = 16'h0800;

	localparam logic [1:0] CFG_WINDOW  = 2'd0;
	localparam logic [1:0] CFG_IDLE    = 2'd1;
	localparam logic [1:0] CFG_RECYCLE = 2'd2;
	// no register at this index
	localparam logic [1:0] CFG_NONE    = 2'd3;

	typedef struct packed {
		logic [15:0] frame_type;
		logic [31:0] src_addr;
		logic [15:0] frame_len;
		logic [31:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic        rate_valid;
		logic [31:0] rate_bytes;
		logic [11:0] rate_scaled;
		logic        rate_in_mib;
		logic        table_full_drop;
		logic        frame_ignored;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan_clear;
		logic scan_step;
		logic update;
		logic sweep_step;
		logic sweep_end;
		logic emit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ignored;
		logic scan_last;
		logic hit;
		logic report;
		logic sweep_due;
	} dp_stat_t;

endpackage
`default_nettype wire

### rtl/per_source_rate_meter.sv
// channel   | handshake          | payload
// frame in  | start / busy       | item   (in_word_t)
// result    | done strobe        | result (out_word_t)
// config    | cfg_we             | cfg_index, cfg_data
// A frame does one table read per cycle from the single-port-read entry RAM,
// then update and result.
// A report that triggers a recycle adds a sweep of the table.
// Non-IPv4 frames skip the search. Reset clears valid bits; config resets to defaults.
// The result is shown for one cycle on done; the receiver cannot stall.
`default_nettype none
module per_source_rate_meter #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire psrm_pkg::in_word_t   item,
	output logic                      done,
	output psrm_pkg::out_word_t       result,
	input  wire                       cfg_we,
	input  wire [1:0]                 cfg_index,
	input  wire [19:0]                cfg_data
);
	psrm_pkg::dp_cmd_t  cmd;
	psrm_pkg::dp_stat_t stat;

	psrm_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat));

	psrm_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (.clk(clk), .arst_n(arst_n),
		.item(item), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat), .done(done), .result(result));
endmodule
`default_nettype wire

### rtl/psrm_ctrl.sv
`default_nettype none
module psrm_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	output psrm_pkg::dp_cmd_t         cmd,
	input  wire psrm_pkg::dp_stat_t   stat
);

	psrm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= psrm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			psrm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d = psrm_pkg::ST_SEARCH;
				end
			end
			psrm_pkg::ST_SEARCH: begin
				if (stat.ignored) begin
					state_d = psrm_pkg::ST_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.scan_last) state_d = psrm_pkg::ST_UPDATE;
				end
			end
			psrm_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				cmd.scan_clear = 1'b1;
				if (stat.hit && stat.report && stat.sweep_due) state_d = psrm_pkg::ST_SWEEP;
				else state_d = psrm_pkg::ST_DONE;
			end
			psrm_pkg::ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.scan_last) begin
					cmd.sweep_end = 1'b1;
					state_d = psrm_pkg::ST_DONE;
				end
			end
			psrm_pkg::ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = psrm_pkg::ST_IDLE;
			end
			default: state_d = psrm_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### rtl/psrm_dp.sv
`default_nettype none
module psrm_dp #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire psrm_pkg::in_word_t   item,
	input  wire                       cfg_we,
	input  wire [1:0]                 cfg_index,
	input  wire [19:0]                cfg_data,
	input  wire psrm_pkg::dp_cmd_t    cmd,
	output psrm_pkg::dp_stat_t        stat,
	output logic                      done,
	output psrm_pkg::out_word_t       result
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	logic [11:0] window_q;
	logic [19:0] idle_q, recycle_q;
	logic [31:0] last_rec_q;
	logic        rec_set_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	psrm_pkg::in_word_t item_q;
	logic [IW-1:0] idx_q;
	logic          first_q;   // first cycle of a scan: read data not yet used
	logic [IW-1:0] rd_idx_q;  // index of entry shown on read data
	logic          hit_q, free_found_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [31:0]   hit_cnt_q, hit_start_q;
	logic          fire_q;
	psrm_pkg::out_word_t res_q;

	// 96-bit entry: key, count, window start
	logic          mem_we;
	logic [IW-1:0] mem_wa, mem_ra;
	logic [95:0]   mem_wd, mem_rd;

	psrm_ram #(.WIDTH(96), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
		.raddr(mem_ra), .rdata(mem_rd)
	);

	wire [31:0] rd_key   = mem_rd[95:64];
	wire [31:0] rd_start = mem_rd[31:0];
	wire        ignored  = item_q.frame_type != psrm_pkg::IPV4_TYPE;
	wire        scanning = cmd.scan_step || cmd.sweep_step;
	wire        rd_ok    = !first_q && scanning;

	// signed elapsed times
	wire [31:0] el_hit = item_q.now_seconds - hit_start_q;
	wire signed [32:0] el_s = {el_hit[31], el_hit};
	wire signed [32:0] win_s = {21'd0, window_q};
	wire        el_eq = el_s == win_s;
	wire        el_gt = (el_s > win_s) || el_hit[31];
	wire [32:0] sum = {1'b0, hit_cnt_q} + {17'd0, item_q.frame_len};
	wire [31:0] sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	wire [31:0] el_rec = item_q.now_seconds - last_rec_q;
	wire        due = !el_rec[31] && (el_rec >= {12'd0, recycle_q});
	wire [31:0] el_idle = item_q.now_seconds - rd_start;
	wire        idle = !el_idle[31] && (el_idle >= {12'd0, idle_q});
	wire        report = hit_q && el_eq && (hit_cnt_q != 32'd0);
	wire        in_mib = hit_cnt_q[31:20] != 12'd0;

	assign stat.ignored   = ignored;
	assign stat.scan_last = !first_q && rd_idx_q == LAST;
	assign stat.hit       = hit_q;
	assign stat.report    = report;
	assign stat.sweep_due = due;

	always_comb begin
		mem_ra = (cmd.scan_clear || first_q) ? '0 : idx_q;
		mem_we = 1'b0;
		mem_wa = hit_idx_q;
		mem_wd = {item_q.src_addr, hit_cnt_q, hit_start_q};
		if (cmd.update) begin
			if (hit_q) begin
				mem_we = 1'b1;
				if (el_eq) mem_wd = {item_q.src_addr, 32'd0, item_q.now_seconds};
				else if (el_gt) mem_wd = {item_q.src_addr, 16'd0, item_q.frame_len,
					item_q.now_seconds};
				else mem_wd = {item_q.src_addr, sat, hit_start_q};
			end else if (free_found_q) begin
				mem_we = 1'b1;
				mem_wa = free_idx_q;
				mem_wd = {item_q.src_addr, 16'd0, item_q.frame_len, item_q.now_seconds};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.scan_clear) begin
			idx_q <= IW'(1);
			rd_idx_q <= '0;
		end else if (scanning) begin
			rd_idx_q <= mem_ra;
			// hold the read address while entry 0 is fetched
			if (!first_q && idx_q != LAST) idx_q <= idx_q + IW'(1);
		end
		if (cmd.scan_clear) begin
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_ok && cmd.scan_step) begin
			if (valid_q[rd_idx_q]) begin
				if (!hit_q && rd_key == item_q.src_addr) begin
					hit_q <= 1'b1;
					hit_idx_q <= rd_idx_q;
					hit_cnt_q <= mem_rd[63:32];
					hit_start_q <= rd_start;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q <= rd_idx_q;
			end
		end
		if (cmd.update) begin
			res_q.rate_valid <= report;
			res_q.rate_bytes <= report ? hit_cnt_q : 32'd0;
			res_q.rate_in_mib <= report && in_mib;
			res_q.rate_scaled <= !report ? 12'd0 : in_mib ? hit_cnt_q[31:20]
				: hit_cnt_q[21:10];
			res_q.table_full_drop <= !hit_q && !free_found_q;
			res_q.frame_ignored <= 1'b0;
		end else if (cmd.load) begin
			res_q <= '{rate_valid: 1'b0, rate_bytes: 32'd0, rate_scaled: 12'd0,
				rate_in_mib: 1'b0, table_full_drop: 1'b0,
				frame_ignored: item.frame_type != psrm_pkg::IPV4_TYPE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 12'd1;
			idle_q <= 20'd10800;
			recycle_q <= 20'd14400;
			last_rec_q <= '0;
			rec_set_q <= 1'b0;
			valid_q <= '0;
			first_q <= 1'b1;
			fire_q <= 1'b0;
		end else begin
			fire_q <= cmd.emit;
			if (cfg_we) begin
				unique case (cfg_index)
					psrm_pkg::CFG_WINDOW:  window_q <= cfg_data[11:0];
					psrm_pkg::CFG_IDLE:    idle_q <= cfg_data;
					psrm_pkg::CFG_RECYCLE: recycle_q <= cfg_data;
					default: ;
				endcase
			end
			first_q <= cmd.scan_clear;
			// first IPv4 word seeds the recycle clock
			if (cmd.load && !rec_set_q && item.frame_type == psrm_pkg::IPV4_TYPE) begin
				rec_set_q <= 1'b1;
				last_rec_q <= item.now_seconds;
			end
			if (cmd.update) begin
				if (hit_q) valid_q[hit_idx_q] <= 1'b1;
				else if (free_found_q) valid_q[free_idx_q] <= 1'b1;
			end
			if (rd_ok && cmd.sweep_step && valid_q[rd_idx_q] && idle)
				valid_q[rd_idx_q] <= 1'b0;
			if (cmd.sweep_end) last_rec_q <= item_q.now_seconds;
		end
	end

	assign done = fire_q;
	assign result = res_q;

endmodule
`default_nettype wire

### rtl/psrm_ram.sv
`default_nettype none
module psrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                               clk,
	input  wire                               we,
	input  wire [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr,
	input  wire [WIDTH-1:0]                   wdata,
	input  wire [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/psrm_checker.sv
`default_nettype none
module psrm_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      start,
	input wire                      busy,
	input wire                      done,
	input wire psrm_pkg::out_word_t result
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $countones({result.rate_valid, result.table_full_drop,
			result.frame_ignored}) <= 1) else $error("conflicting flags");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.rate_valid |-> result.rate_bytes == 32'd0)
		else $error("rate without valid");
endmodule

bind per_source_rate_meter psrm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .result(result));
`default_nettype wire
